// File: rtl/core/mvfb_pkg.sv
// Shared types, constants and the CRC-16/MCRF4XX byte update for the frame builder.
// No dependencies.
package mvfb_pkg;

    localparam logic [7:0]  FRAME_MAGIC   = 8'hFD;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam int          HDR_BYTES     = 10;
    localparam int          HDR_IDX_W     = 4;
    localparam int          CFG_IDX_W     = 4;
    localparam int          CFG_DATA_W    = 24;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_MAGIC = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN   = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_INC   = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_CMP   = 4'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_SEQ   = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_SYS   = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_COMP  = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_MSG0  = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_MSG1  = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_MSG2  = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_IDENT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_IDENT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_IDENT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH  = 4'd3;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    // where the emitter stands inside the held word
    typedef struct packed {
        t_phase                 phase;
        logic [HDR_IDX_W-1:0]   hdr_idx;
    } t_emit_ctrl;

    // id registers seen by the header mux
    typedef struct packed {
        logic [7:0]  sys_id;
        logic [7:0]  comp_id;
        logic [23:0] msg_id;
        logic [7:0]  length;
    } t_hdr_cfg;

    // one byte of CRC-16/MCRF4XX (reflected 0x1021)
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// File: rtl/core/mvfb_byte_gen.sv
// Byte selector and CRC step: picks the wire byte for the current emit position
// and computes the running CRC after it. Depends on mvfb_pkg.
module mvfb_byte_gen (
    input  mvfb_pkg::t_emit_ctrl i_ctrl,
    input  mvfb_pkg::t_hdr_cfg   i_cfg,
    input  logic [7:0]           i_seq,
    input  logic [7:0]           i_data,
    input  logic [15:0]          i_crc,
    output logic [7:0]           o_byte,
    output logic [15:0]          o_crc
);
    import mvfb_pkg::*;

    logic [7:0] hdr_byte;

    // header field mux
    always_comb begin
        case (i_ctrl.hdr_idx)
            HDR_MAGIC: hdr_byte = FRAME_MAGIC;
            HDR_LEN:   hdr_byte = i_cfg.length;
            HDR_INC:   hdr_byte = 8'h00;
            HDR_CMP:   hdr_byte = 8'h00;
            HDR_SEQ:   hdr_byte = i_seq;
            HDR_SYS:   hdr_byte = i_cfg.sys_id;
            HDR_COMP:  hdr_byte = i_cfg.comp_id;
            HDR_MSG0:  hdr_byte = i_cfg.msg_id[7:0];
            HDR_MSG1:  hdr_byte = i_cfg.msg_id[15:8];
            HDR_MSG2:  hdr_byte = i_cfg.msg_id[23:16];
            default:   hdr_byte = 8'h00;
        endcase
    end

    // wire byte and CRC after it; magic byte restarts the CRC
    always_comb begin
        case (i_ctrl.phase)
            PH_HDR: begin
                o_byte = hdr_byte;
                o_crc  = (i_ctrl.hdr_idx == HDR_MAGIC) ? CRC_SEED : crc_feed(i_crc, hdr_byte);
            end
            PH_DATA: begin
                o_byte = i_data;
                o_crc  = crc_feed(i_crc, i_data);
            end
            PH_CRC_LO: begin
                o_byte = i_crc[7:0];
                o_crc  = i_crc;
            end
            PH_CRC_HI: begin
                o_byte = i_crc[15:8];
                o_crc  = CRC_SEED;
            end
            default: begin
                o_byte = 8'h00;
                o_crc  = i_crc;
            end
        endcase
    end

endmodule

// File: rtl/core/mavlink_v2_frame_builder_unit.sv
// Top level of the MAVLink v2 frame builder: input word register, byte emitter,
// configuration registers and output register. Depends on mvfb_pkg, mvfb_byte_gen.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one payload byte per word.
//   Output channel (o_out_valid/i_out_ready) gives one wire byte per word,
//   with o_run_last on the last byte caused by an input word and o_frame_end
//   on the high CRC byte that closes a frame.
//   The first payload byte of a frame yields 10 header bytes plus itself;
//   the byte that completes payload_length yields itself plus 2 CRC bytes.
//   Throughput: one output byte per cycle from a single byte emitter while the
//   receiver does not stall the output. A held word accepts its successor in
//   the cycle its last byte is emitted. A taken word waits in the input word
//   register and its bytes go out through the output register.
//   Configuration: i_cfg_we/i_cfg_index/i_cfg_data, for the user to write only
//   when idle; the block does not enforce this. Unknown indexes are ignored.
//   Id changes show in the next header.
//   Reset (synchronous, active low) empties both registers, clears the
//   sequence number and payload count, and loads register defaults.
//   A stalled receiver holds the output byte; the emitter and then the
//   input stall behind it with nothing lost.
module mavlink_v2_frame_builder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mvfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mvfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_payload_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_frame_byte,
    output logic                            o_run_last,
    output logic                            o_frame_end
);
    import mvfb_pkg::*;

    // configuration
    logic [7:0]  r_sys_id;
    logic [7:0]  r_comp_id;
    logic [23:0] r_msg_id;
    logic [7:0]  r_length;

    // frame state
    logic [7:0]  r_seq,   n_seq;
    logic [15:0] r_crc,   n_crc;
    logic [7:0]  r_count, n_count;

    // held input word and emit position
    logic        r_item_valid, n_item_valid;
    logic [7:0]  r_item_byte;
    t_emit_ctrl  r_ctrl, n_ctrl;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_end;

    t_hdr_cfg    hdr_cfg;
    logic [7:0]  gen_byte;
    logic [15:0] gen_crc;
    logic        emit;
    logic        emit_last;
    logic        in_take;
    logic [7:0]  count_inc;

    assign hdr_cfg = '{sys_id: r_sys_id, comp_id: r_comp_id, msg_id: r_msg_id,
                       length: r_length};

    mvfb_byte_gen u_byte_gen (
        .i_ctrl (r_ctrl),
        .i_cfg  (hdr_cfg),
        .i_seq  (r_seq),
        .i_data (r_item_byte),
        .i_crc  (r_crc),
        .o_byte (gen_byte),
        .o_crc  (gen_crc)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_id  <= 8'd1;
            r_comp_id <= 8'd1;
            r_msg_id  <= 24'd9000;
            r_length  <= 8'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SYSTEM_IDENT:    r_sys_id  <= i_cfg_data[7:0];
                REG_COMPONENT_IDENT: r_comp_id <= i_cfg_data[7:0];
                REG_MESSAGE_IDENT:   r_msg_id  <= i_cfg_data[23:0];
                REG_PAYLOAD_LENGTH:  r_length  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign emit      = r_item_valid && (!r_out_valid || i_out_ready);
    assign count_inc = r_count + 8'd1;
    assign o_in_ready = !r_item_valid || (emit && emit_last);
    assign in_take    = i_in_valid && o_in_ready;

    // last byte of the held word
    always_comb begin
        case (r_ctrl.phase)
            PH_DATA:   emit_last = (count_inc != r_length);
            PH_CRC_HI: emit_last = 1'b1;
            default:   emit_last = 1'b0;
        endcase
    end

    // emitter sequencing
    always_comb begin
        n_seq        = r_seq;
        n_crc        = r_crc;
        n_count      = r_count;
        n_ctrl       = r_ctrl;
        n_item_valid = r_item_valid;
        n_out_valid  = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_crc       = gen_crc;
            case (r_ctrl.phase)
                PH_HDR: begin
                    if (r_ctrl.hdr_idx == HDR_SEQ) begin
                        n_seq = r_seq + 8'd1;
                    end
                    if (r_ctrl.hdr_idx == HDR_MSG2) begin
                        n_ctrl.phase = PH_DATA;
                    end
                    n_ctrl.hdr_idx = r_ctrl.hdr_idx + 4'd1;
                end
                PH_DATA: begin
                    if (count_inc == r_length) begin
                        n_count      = 8'd0;
                        n_ctrl.phase = PH_CRC_LO;
                    end else begin
                        n_count      = count_inc;
                    end
                end
                PH_CRC_LO: n_ctrl.phase = PH_CRC_HI;
                PH_CRC_HI: n_ctrl.phase = PH_DATA;
                default:   n_ctrl.phase = PH_DATA;
            endcase
            if (emit_last) begin
                n_item_valid = 1'b0;
            end
        end

        // new word: header first when no frame is open
        if (in_take) begin
            n_item_valid   = 1'b1;
            n_ctrl.hdr_idx = HDR_MAGIC;
            n_ctrl.phase   = (n_count == 8'd0) ? PH_HDR : PH_DATA;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= 8'd0;
            r_crc        <= CRC_SEED;
            r_count      <= 8'd0;
            r_item_valid <= 1'b0;
            r_ctrl       <= '{phase: PH_DATA, hdr_idx: HDR_MAGIC};
            r_out_valid  <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_crc        <= n_crc;
            r_count      <= n_count;
            r_item_valid <= n_item_valid;
            r_ctrl       <= n_ctrl;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item_byte <= i_payload_byte;
        end
        if (emit) begin
            r_out_byte <= gen_byte;
            r_out_last <= emit_last;
            r_out_end  <= (r_ctrl.phase == PH_CRC_HI);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_run_last   = r_out_last;
    assign o_frame_end  = r_out_end;

endmodule
